FILE: rtl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, constants and helpers of the macroblock colour converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  typedef enum logic {
    KindStore   = 1'b0,
    KindConvert = 1'b1
  } y2r_kind_e;

  // Item handed from the front end to the back end.
  typedef struct packed {
    y2r_kind_e  kind;
    logic [3:0] crow;
    logic [3:0] ccol;
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } y2r_item_t;

  localparam int QueueDepth = 4;

  localparam logic [7:0]        YBias   = 8'd16;
  localparam logic [7:0]        CoefY   = 8'd149;
  localparam logic signed [9:0] CoefRcr = 10'sd204;
  localparam logic signed [9:0] CoefGcr = -10'sd104;
  localparam logic signed [9:0] CoefGcb = -10'sd50;
  localparam logic signed [9:0] CoefBcb = 10'sd258;
  localparam logic [7:0]        AlphaValue = 8'h80;

  // Saturate a halved channel sum to 0..255.
  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] r;
    if (v[10]) begin
      r = 8'd0;
    end else if (|v[9:8]) begin
      r = 8'hff;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/y2r_ram.sv
// ----------------------------------------------------------------------------
// y2r_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module y2r_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/y2r_front.sv
// ----------------------------------------------------------------------------
// y2r_front
// Input side: accepts items, drops out-of-range ones, maps convert pixel
// position to chroma position and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module y2r_front #(
  parameter int BLOCK_SIDE = 16
) (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,
  input  logic               s_axis_tuser_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output y2r_pkg::y2r_item_t q_item_o
);
  import y2r_pkg::*;

  localparam int ChromaSide = (BLOCK_SIDE + 1) / 2;

  y2r_kind_e  kind;
  logic [3:0] row;
  logic [3:0] col;
  logic       in_range;

  assign kind = y2r_kind_e'(s_axis_tuser_i);
  assign row  = s_axis_tdata_i[3:0];
  assign col  = s_axis_tdata_i[7:4];

  always_comb begin
    unique case (kind)
      KindStore:   in_range = (int'(row) < ChromaSide) && (int'(col) < ChromaSide);
      KindConvert: in_range = (int'(row) < BLOCK_SIDE) && (int'(col) < BLOCK_SIDE);
      default:     in_range = 1'b0;
    endcase
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i && in_range;

  always_comb begin
    q_item_o.kind = kind;
    q_item_o.crow = (kind == KindConvert) ? {1'b0, row[3:1]} : row;
    q_item_o.ccol = (kind == KindConvert) ? {1'b0, col[3:1]} : col;
    q_item_o.luma = s_axis_tdata_i[15:8];
    q_item_o.cb   = s_axis_tdata_i[23:16];
    q_item_o.cr   = s_axis_tdata_i[31:24];
  end

endmodule

FILE: rtl/y2r_fifo.sv
// ----------------------------------------------------------------------------
// y2r_fifo
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
module y2r_fifo #(
  parameter int Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  y2r_pkg::y2r_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output y2r_pkg::y2r_item_t item_o
);
  import y2r_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  y2r_item_t       buf_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/y2r_back.sv
// ----------------------------------------------------------------------------
// y2r_back
// Execution side: chroma memory writes and reads, BT.601 products, channel
// sums and clamp, output register.
// ----------------------------------------------------------------------------
module y2r_back #(
  parameter int BLOCK_SIDE = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  y2r_pkg::y2r_item_t q_item_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o
);
  import y2r_pkg::*;

  localparam int ChromaSide  = (BLOCK_SIDE + 1) / 2;
  localparam int ChromaDepth = ChromaSide * ChromaSide;
  localparam int AddrW       = (ChromaDepth > 1) ? $clog2(ChromaDepth) : 1;

  logic             advance;
  logic             is_store;
  logic             is_conv;
  logic [AddrW-1:0] addr;
  logic [15:0]      chroma;

  assign advance  = !m_axis_tvalid_o || m_axis_tready_i;
  assign q_pop_o  = advance && q_valid_i;
  assign is_store = q_pop_o && (q_item_i.kind == KindStore);
  assign is_conv  = q_pop_o && (q_item_i.kind == KindConvert);
  assign addr     = AddrW'(int'(q_item_i.crow) * ChromaSide + int'(q_item_i.ccol));

  // chroma word: cb low, cr high
  y2r_ram #(
    .Width (16),
    .Depth (ChromaDepth),
    .AddrW (AddrW)
  ) u_chroma_ram (
    .clk_i   (clk_i),
    .we_i    (is_store),
    .waddr_i (addr),
    .wdata_i ({q_item_i.cr, q_item_i.cb}),
    .re_i    (is_conv),
    .raddr_i (addr),
    .rdata_o (chroma)
  );

  // stage 1: chroma read back
  logic       s1_valid_q;
  logic [7:0] s1_luma_q;

  // stage 2: scaled products
  logic s2_valid_q;
  logic [9:0]         lum_q, lum_d;
  logic signed [9:0]  rcr_q, rcr_d;
  logic signed [8:0]  gcr_q, gcr_d;
  logic signed [7:0]  gcb_q, gcb_d;
  logic signed [10:0] bcb_q, bcb_d;

  logic [7:0]         yp;
  logic [15:0]        p_lum;
  logic signed [7:0]  cb_s, cr_s;
  logic signed [17:0] p_rcr, p_gcr, p_gcb, p_bcb;

  always_comb begin
    yp    = (s1_luma_q > YBias) ? s1_luma_q - YBias : 8'd0;
    cb_s  = {~chroma[7], chroma[6:0]};
    cr_s  = {~chroma[15], chroma[14:8]};
    p_lum = yp * CoefY;
    p_rcr = cr_s * CoefRcr;
    p_gcr = cr_s * CoefGcr;
    p_gcb = cb_s * CoefGcb;
    p_bcb = cb_s * CoefBcb;
    lum_d = p_lum[15:6];
    rcr_d = p_rcr[15:6];
    gcr_d = p_gcr[14:6];
    gcb_d = p_gcb[13:6];
    bcb_d = p_bcb[16:6];
  end

  // stage 3: sums, rounding halve, clamp
  logic signed [11:0] sum_r, sum_g, sum_b;
  logic [31:0]        out_d;

  always_comb begin
    sum_r = $signed({2'b00, lum_q}) + rcr_q + 12'sd1;
    sum_g = $signed({2'b00, lum_q}) + gcr_q + gcb_q + 12'sd1;
    sum_b = $signed({2'b00, lum_q}) + bcb_q + 12'sd1;
    out_d = {AlphaValue, clamp_byte(sum_b[11:1]), clamp_byte(sum_g[11:1]),
             clamp_byte(sum_r[11:1])};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      s2_valid_q      <= 1'b0;
      m_axis_tvalid_o <= 1'b0;
    end else if (advance) begin
      s1_valid_q      <= is_conv;
      s2_valid_q      <= s1_valid_q;
      m_axis_tvalid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_luma_q      <= q_item_i.luma;
      lum_q          <= lum_d;
      rcr_q          <= rcr_d;
      gcr_q          <= gcr_d;
      gcb_q          <= gcb_d;
      bcb_q          <= bcb_d;
      m_axis_tdata_o <= out_d;
    end
  end

endmodule

FILE: rtl/ycbcr420_to_rgba_macroblock_core.sv
// ----------------------------------------------------------------------------
// ycbcr420_to_rgba_macroblock_core
// 4:2:0 YCbCr to RGBA converter for one macroblock, integer BT.601.
//
//   channel  dir  tdata (low bit up)                       tuser
//   s_axis   in   row[3:0] col[7:4] luma[15:8]             cmd (0 store,
//                 cb_sample[23:16] cr_sample[31:24]         1 convert)
//   m_axis   out  red[7:0] green[15:8] blue[23:16]          -
//                 alpha[31:24]
//
// One item per cycle sustained unless the output stalls. A convert
// result passes the queue, the registered chroma RAM read, the product
// stage and the output register. Out-of-range items and stores give no
// result. A stalled output freezes the back end; the input keeps taking
// items until the four-entry queue fills. Reset clears control only; the
// chroma memory is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module ycbcr420_to_rgba_macroblock_core #(
  parameter int BLOCK_SIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // row, col, luma, cb_sample, cr_sample
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // red, green, blue, alpha
);
  import y2r_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  y2r_item_t q_in;
  y2r_item_t q_out;

  y2r_front #(
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  y2r_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  y2r_back #(
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

FILE: test/ycbcr420_to_rgba_macroblock_core_test.sv
// ----------------------------------------------------------------------------
// ycbcr420_to_rgba_macroblock_core_test
// Self-checking bench for the macroblock colour converter. A queue of
// store and convert items feeds a stream driver, and each accepted item
// is run through a bench-side BT.601 predictor with its own chroma
// memory. A monitor compares every pixel with the oldest prediction.
// Both ends idle at random, the output is held off for a long stretch
// and the input pauses once until all pixels are out.
// ----------------------------------------------------------------------------
module ycbcr420_to_rgba_macroblock_core_test;
  import y2r_pkg::*;

  localparam int BlockSide   = 16;
  localparam int ChromaSide  = (BlockSide + 1) / 2;
  localparam int ChromaDepth = ChromaSide * ChromaSide;
  localparam int StallLimit  = 4000;
  localparam int TailCycles  = 10;

  typedef struct {
    y2r_kind_e  kind;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // row, col, luma, cb_sample, cr_sample
  logic        s_axis_tuser = 1'b0;  // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // red, green, blue, alpha

  ycc_item_t ycc_items[$];
  rgba_t     expected_pixels[$];
  logic      chroma_loaded[ChromaDepth];
  logic [7:0] chroma_cb[ChromaDepth];
  logic [7:0] chroma_cr[ChromaDepth];

  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic send_hold = 1'b0;
  logic recv_hold = 1'b0;
  int   stall_cycles = 0;

  ycbcr420_to_rgba_macroblock_core #(
    .BLOCK_SIDE(BlockSide)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] sat_byte(int v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 255) begin
      return 8'hff;
    end
    return v[7:0];
  endfunction

  function automatic rgba_t bt601_pixel(logic [7:0] y, logic [7:0] cb8, logic [7:0] cr8);
    int    yp;
    int    cb;
    int    cr;
    int    lum;
    rgba_t px;
    yp  = (int'(y) > int'(YBias)) ? int'(y) - int'(YBias) : 0;
    cb  = int'(cb8) - 128;
    cr  = int'(cr8) - 128;
    lum = (int'(CoefY) * yp) >>> 6;
    px.red   = sat_byte((lum + ((int'(CoefRcr) * cr) >>> 6) + 1) >>> 1);
    px.green = sat_byte((lum + ((int'(CoefGcr) * cr) >>> 6)
                         + ((int'(CoefGcb) * cb) >>> 6) + 1) >>> 1);
    px.blue  = sat_byte((lum + ((int'(CoefBcb) * cb) >>> 6) + 1) >>> 1);
    px.alpha = AlphaValue;
    return px;
  endfunction

  // Updates the chroma memory or queues the pixel that the item yields.
  task automatic predict_item(ycc_item_t it);
    int addr;
    if (it.kind == KindStore) begin
      if (it.row < ChromaSide && it.col < ChromaSide) begin
        addr = it.row * ChromaSide + it.col;
        chroma_cb[addr] = it.cb;
        chroma_cr[addr] = it.cr;
      end
    end else if (it.row < BlockSide && it.col < BlockSide) begin
      addr = (it.row >> 1) * ChromaSide + (it.col >> 1);
      expected_pixels.push_back(bt601_pixel(it.luma, chroma_cb[addr], chroma_cr[addr]));
    end
  endtask

  task automatic queue_store(logic [3:0] r, logic [3:0] c, logic [7:0] cbv, logic [7:0] crv);
    ycc_item_t it;
    it = '{KindStore, r, c, 8'($urandom), cbv, crv};
    ycc_items.push_back(it);
    if (r < ChromaSide && c < ChromaSide) begin
      chroma_loaded[r * ChromaSide + c] = 1'b1;
    end
  endtask

  // Chroma is loaded first where the position has never been written.
  task automatic queue_convert(logic [3:0] r, logic [3:0] c, logic [7:0] y);
    ycc_item_t it;
    int        addr;
    addr = (r >> 1) * ChromaSide + (c >> 1);
    if (!chroma_loaded[addr]) begin
      queue_store(r >> 1, c >> 1, 8'($urandom), 8'($urandom));
    end
    it = '{KindConvert, r, c, y, 8'($urandom), 8'($urandom)};
    ycc_items.push_back(it);
  endtask

  task automatic queue_random(int n);
    int target;
    target = ycc_items.size() + n;
    while (ycc_items.size() < target) begin
      if ($urandom_range(99) < 20) begin
        queue_store(4'($urandom_range(15)), 4'($urandom_range(15)),
                    8'($urandom), 8'($urandom));
      end else begin
        queue_convert(4'($urandom_range(15)), 4'($urandom_range(15)), 8'($urandom));
      end
    end
  endtask

  task automatic drain_stream();
    while (ycc_items.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : item_driver
    logic      fire;
    ycc_item_t it;
    fire = s_axis_tvalid && s_axis_tready;
    if (fire) begin
      predict_item(ycc_items.pop_front());
    end
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !fire) begin
      s_axis_tvalid <= 1'b1;
    end else if (ycc_items.size() != 0 && !send_hold
                 && $urandom_range(99) >= send_idle_pct) begin
      it = ycc_items[0];
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= it.kind;
      s_axis_tdata  <= {it.cr, it.cb, it.luma, it.col, it.row};
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin : pixel_monitor
    rgba_t got;
    rgba_t want;
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("** ycbcr420_to_rgba_macroblock_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    foreach (chroma_loaded[i]) begin
      chroma_loaded[i] = 1'b0;
      chroma_cb[i] = '0;
      chroma_cr[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, green saturation, out-of-range stores, overwrite
    queue_store(4'd0, 4'd0, 8'h00, 8'h00);
    queue_convert(4'd0, 4'd0, 8'h00);
    queue_convert(4'd1, 4'd1, 8'hff);
    queue_convert(4'd0, 4'd1, 8'd16);
    queue_store(4'd7, 4'd7, 8'hff, 8'hff);
    queue_convert(4'd15, 4'd15, 8'hff);
    queue_convert(4'd14, 4'd14, 8'h00);
    queue_store(4'd0, 4'd7, 8'h00, 8'hff);
    queue_convert(4'd0, 4'd15, 8'd128);
    queue_store(4'd7, 4'd0, 8'hff, 8'h00);
    queue_convert(4'd15, 4'd0, 8'd235);
    queue_store(4'd3, 4'd4, 8'd128, 8'd128);
    queue_convert(4'd7, 4'd8, 8'd17);
    queue_convert(4'd6, 4'd9, 8'd15);
    queue_store(4'd8, 4'd0, 8'haa, 8'h55);
    queue_store(4'd0, 4'd8, 8'h55, 8'haa);
    queue_store(4'd15, 4'd15, 8'haa, 8'h55);
    queue_convert(4'd0, 4'd0, 8'd200);
    queue_convert(4'd15, 4'd15, 8'd200);
    queue_store(4'd0, 4'd0, 8'h7f, 8'h81);
    queue_convert(4'd1, 4'd0, 8'd100);
    drain_stream();

    send_idle_pct <= 8;
    recv_idle_pct <= 77;
    queue_random(550);
    while (ycc_items.size() > 270) @(posedge clk);
    send_hold <= 1'b1;
    do @(posedge clk); while (s_axis_tvalid || expected_pixels.size() != 0);
    send_hold <= 1'b0;
    drain_stream();

    send_idle_pct <= 77;
    recv_idle_pct <= 8;
    queue_random(550);
    drain_stream();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random(550);
    @(posedge clk);
    recv_hold <= 1'b1;
    fork
      begin
        repeat (80) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none

    while (ycc_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("** ycbcr420_to_rgba_macroblock_core: PASSED **");
    end else begin
      $display("** ycbcr420_to_rgba_macroblock_core: FAILED **");
    end
    $finish;
  end

endmodule
